[src/assert_macros.svh]
// Assertion macros for the RTL of the audio peak meter.
// No dependencies; each file that asserts includes this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define APM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define APM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/apm_pkg.sv]
// Package for the audio peak meter with hold: widths, codes, state and command types.
// No dependencies; used by the controller, the datapath, the root unit and the top level.
package apm_pkg;

   localparam int unsigned FULL_SCALE  = 1000;
   localparam int unsigned LEVEL_W     = 10;
   localparam int unsigned SAMPLE_W    = 32;
   localparam int unsigned REQ_TYPE_W  = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 2;

   // floor(1.15 * sqrt(FULL_SCALE * p)) equals isqrt(floor(p * METER_MUL / 2)).
   localparam int unsigned METER_MUL   = (FULL_SCALE * 13225 * 2) / 10000;
   localparam int unsigned METER_SHIFT = 1;
   localparam int unsigned METER_MUL_W = $clog2(METER_MUL + 1);
   localparam int unsigned SQRT_IN_W   = ((LEVEL_W + METER_MUL_W - METER_SHIFT + 1) / 2) * 2;
   localparam int unsigned SQRT_OUT_W  = SQRT_IN_W / 2;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_FRAME = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_FORMAT  = 2'd0,
      CSR_STEREO         = 2'd1,
      CSR_RESPONSE_SPEED = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_INT16 = 2'd0,
      FMT_INT24 = 2'd1,
      FMT_INT32 = 2'd2,
      FMT_FLOAT = 2'd3
   } sample_format_type;

   typedef enum logic [1:0] {
      SPEED_FAST   = 2'd0,
      SPEED_NORMAL = 2'd1,
      SPEED_SLOW   = 2'd2
   } response_speed_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRAME_MUL,
      ST_FRAME_MERGE,
      ST_TICK_PREP,
      ST_TICK_SQRT,
      ST_TICK_OUT
   } state_type;

   typedef struct packed {
      logic latch_frame;
      logic frame_mul;
      logic frame_merge;
      logic clear_hold;
      logic tick_prep;
      logic tick_commit;
   } cmd_type;

   typedef struct packed {
      logic sqrt_busy;
   } status_type;

endpackage

[src/audio_peak_meter_with_hold.sv]
// Audio peak program meter with peak hold. Each request transaction carries one
// audio frame, a meter tick or a clear of the hold. Frames (16-, 24- or 32-bit
// two's complement, or IEEE single float) are scaled to thousandths of full scale,
// truncated, clipped at 1000 and max-merged into a running peak; silent frames and
// request code three are taken and dropped. A tick returns one response transaction
// with the peak, the bar level floor(1.15*sqrt(1000*peak)) capped at 1000, and the
// updated hold, then decays the peak to 70, 88 or 95 percent. Clear and frame
// requests give no response. A non-silent frame runs through the accepting cycle, a
// multiply stage and a merge stage; a silent frame, a clear or code three ends on
// acceptance; a tick runs the bit-serial square root, which resolves one of its 11
// result bits per cycle. A finished tick result sits in an output register, so new
// requests are taken while it waits; a second tick only stalls in its last cycle if
// the earlier result has still not been taken. Configuration writes go through the
// csr port; the user must do so only while the block is idle; it is not enforced.
// Depends on apm_pkg, apm_ctrl, apm_datapath and assert_macros.svh.
`include "assert_macros.svh"

module audio_peak_meter_with_hold (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [apm_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [apm_pkg::SAMPLE_W-1:0]       req_left_sample,
   input  logic [apm_pkg::SAMPLE_W-1:0]       req_right_sample,
   input  logic                               req_silent,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [apm_pkg::LEVEL_W-1:0]        rsp_peak_level,
   output logic [apm_pkg::LEVEL_W-1:0]        rsp_meter_level,
   output logic [apm_pkg::LEVEL_W-1:0]        rsp_hold_level,
   // Configuration writes.
   input  logic                               csr_we,
   input  logic [apm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [apm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [apm_pkg::LEVEL_W-1:0] FS_LEVEL = apm_pkg::LEVEL_W'(apm_pkg::FULL_SCALE);

   apm_pkg::cmd_type    cmd;
   apm_pkg::status_type status;

   // The controller sequences one request transaction at a time and owns the
   // response valid; the datapath holds settings, peak, hold and the result payload.
   apm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_type),
      .req_silent (req_silent),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   apm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_meter_level  (rsp_meter_level),
      .rsp_hold_level   (rsp_hold_level)
   );

   // A tick result is only loaded when the output register is free or draining.
   `APM_ASSERT_NOW(a_commit_needs_room, clock, reset, cmd.tick_commit, !rsp_valid || rsp_ready, "tick result loaded over an untaken response")
   // Every committed tick shows up as a response in the next cycle.
   `APM_ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.tick_commit, rsp_valid, "committed tick produced no response")
   // While a frame or tick is in flight no new request is taken.
   `APM_ASSERT_NOW(a_busy_blocks_requests, clock, reset, cmd.frame_mul || cmd.frame_merge || cmd.tick_prep || cmd.tick_commit, !req_ready, "request accepted while busy")
   // All reported levels stay within full scale.
   `APM_ASSERT_NOW(a_levels_in_range, clock, reset, rsp_valid, (rsp_peak_level <= FS_LEVEL) && (rsp_meter_level <= FS_LEVEL) && (rsp_hold_level <= FS_LEVEL), "response level above full scale")
   // The bar level is zero exactly when the peak is zero.
   `APM_ASSERT_NOW(a_meter_zero_iff_peak_zero, clock, reset, rsp_valid, (rsp_meter_level == '0) == (rsp_peak_level == '0), "bar level disagrees with zero peak")

endmodule

[src/apm_isqrt.sv]
// Bit-serial integer square root, one result bit per clock.
// Depends on apm_pkg for the operand and result widths.
module apm_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [apm_pkg::SQRT_IN_W-1:0]    radicand,
   output logic                             busy,
   output logic [apm_pkg::SQRT_OUT_W-1:0]   root
);

   localparam int unsigned IN_W  = apm_pkg::SQRT_IN_W;
   localparam int unsigned OUT_W = apm_pkg::SQRT_OUT_W;
   localparam int unsigned REM_W = OUT_W + 2;
   localparam int unsigned CNT_W = $clog2(OUT_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IN_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [OUT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0] rem_try;
   logic [REM_W-1:0] trial;

   // The partial remainder stays at most twice the partial root, so its top
   // two bits are free to take the next radicand pair.
   always_comb begin
      rem_try = {rem_ff[REM_W-3:0], rad_ff[IN_W-1 -: 2]};
      trial   = {root_ff[REM_W-3:0], 2'b01};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(OUT_W);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         busy_in = (cnt_ff != CNT_W'(1));
         cnt_in  = cnt_ff - CNT_W'(1);
         rad_in  = rad_ff << 2;
         if (rem_try >= trial) begin
            rem_in  = rem_try - trial;
            root_in = {root_ff[OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_try;
            root_in = {root_ff[OUT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

[src/apm_datapath.sv]
// Datapath of the audio peak meter: settings, sample scaling, peak and hold, tick results.
// Depends on apm_pkg and instantiates apm_isqrt.
module apm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  apm_pkg::cmd_type                   cmd,
   output apm_pkg::status_type                status,
   input  logic                               csr_we,
   input  logic [apm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [apm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [apm_pkg::SAMPLE_W-1:0]       req_left_sample,
   input  logic [apm_pkg::SAMPLE_W-1:0]       req_right_sample,
   output logic [apm_pkg::LEVEL_W-1:0]        rsp_peak_level,
   output logic [apm_pkg::LEVEL_W-1:0]        rsp_meter_level,
   output logic [apm_pkg::LEVEL_W-1:0]        rsp_hold_level
);

   localparam int unsigned LEVEL_W  = apm_pkg::LEVEL_W;
   localparam int unsigned SAMPLE_W = apm_pkg::SAMPLE_W;
   localparam int unsigned PROD_W   = SAMPLE_W + $clog2(apm_pkg::FULL_SCALE + 1);
   localparam int unsigned SHAMT_W  = $clog2(PROD_W);
   localparam int unsigned MPROD_W  = LEVEL_W + apm_pkg::METER_MUL_W;
   // Percent scaling is a multiply by the scaled, rounded-up fraction; the error stays
   // below one hundredth for any level, so the floor is exact.
   localparam int unsigned DECAY_S  = $clog2(100 * apm_pkg::FULL_SCALE) + 1;
   localparam int unsigned DPROD_W  = LEVEL_W + DECAY_S;
   localparam logic [DECAY_S-1:0] K_FAST   = DECAY_S'((70 * (1 << DECAY_S) + 99) / 100);
   localparam logic [DECAY_S-1:0] K_NORMAL = DECAY_S'((88 * (1 << DECAY_S) + 99) / 100);
   localparam logic [DECAY_S-1:0] K_SLOW   = DECAY_S'((95 * (1 << DECAY_S) + 99) / 100);
   localparam logic [DECAY_S-1:0] K_HOLD   = DECAY_S'((98 * (1 << DECAY_S) + 99) / 100);
   localparam logic [LEVEL_W-1:0] FS_LEVEL = LEVEL_W'(apm_pkg::FULL_SCALE);
   localparam logic [PROD_W-1:0]  FS_PROD  = PROD_W'(apm_pkg::FULL_SCALE);
   // Exponent at which a float mantissa has its binary point at bit zero.
   localparam logic [7:0]         FLOAT_SHIFT_BASE = 8'd150;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mant;
      logic [SHAMT_W-1:0]  shamt;
      logic                full;
   } chan_info_type;

   // Level = floor(mant * FULL_SCALE / 2^shamt), or full scale when forced.
   function automatic chan_info_type decode(input logic [SAMPLE_W-1:0] word,
                                            input apm_pkg::sample_format_type fmt);
      logic [15:0]   v16;
      logic [23:0]   v24;
      logic [31:0]   v32;
      logic [15:0]   mag16;
      logic [23:0]   mag24;
      logic [7:0]    e;
      logic [23:0]   m;
      logic [7:0]    sh;
      chan_info_type info;
      v16  = word[15:0];
      v24  = word[23:0];
      v32  = word;
      // The negation stays at the sample width, so the most negative code
      // gives a magnitude of exactly half the code range.
      mag16 = v16[15] ? -v16 : v16;
      mag24 = v24[23] ? -v24 : v24;
      e    = word[30:23];
      m    = {1'b0, word[22:0]};
      sh   = '0;
      info = '0;
      unique case (fmt)
         apm_pkg::FMT_INT16: begin
            info.mant  = SAMPLE_W'(mag16);
            info.shamt = SHAMT_W'(15);
         end
         apm_pkg::FMT_INT24: begin
            info.mant  = SAMPLE_W'(mag24);
            info.shamt = SHAMT_W'(23);
         end
         apm_pkg::FMT_INT32: begin
            info.mant  = v32[31] ? -v32 : v32;
            info.shamt = SHAMT_W'(31);
         end
         apm_pkg::FMT_FLOAT: begin
            if (e == 8'hFF) begin
               // Infinity reads full scale; NaN reads as silence.
               info.full = (m == '0);
            end else begin
               if (e == 8'h00) begin
                  e = 8'h01;
               end else begin
                  m[23] = 1'b1;
               end
               if (e >= FLOAT_SHIFT_BASE) begin
                  info.full = 1'b1;
               end else begin
                  sh = FLOAT_SHIFT_BASE - e;
                  if (sh < 8'(PROD_W)) begin
                     info.mant  = SAMPLE_W'(m);
                     info.shamt = sh[SHAMT_W-1:0];
                  end
               end
            end
         end
         default: info = '0;
      endcase
      return info;
   endfunction

   function automatic logic [LEVEL_W-1:0] clip(input logic [PROD_W-1:0]  prod,
                                               input logic [SHAMT_W-1:0] shamt,
                                               input logic               full);
      logic [PROD_W-1:0] shifted;
      shifted = prod >> shamt;
      return (full || shifted > FS_PROD) ? FS_LEVEL : shifted[LEVEL_W-1:0];
   endfunction

   // Settings.
   apm_pkg::sample_format_type fmt_ff, fmt_in;
   logic                       stereo_ff, stereo_in;
   logic [1:0]                 speed_ff, speed_in;

   // Meter state.
   logic [LEVEL_W-1:0] peak_ff, peak_in;
   logic [LEVEL_W-1:0] hold_ff, hold_in;

   // Frame pipeline, one lane per channel.
   chan_info_type      info_ff [2];
   chan_info_type      info_in [2];
   logic [PROD_W-1:0]  prod_ff [2];
   logic [PROD_W-1:0]  prod_in [2];
   logic [LEVEL_W-1:0] lvl [2];
   logic [LEVEL_W-1:0] merged;

   // Tick values.
   logic [DECAY_S-1:0]    keep_k;
   logic [DPROD_W-1:0]    decay_prod;
   logic [DPROD_W-1:0]    hold_prod;
   logic [MPROD_W-1:0]    meter_prod;
   logic [LEVEL_W-1:0]    decay_ff, decay_in;
   logic [LEVEL_W-1:0]    hold98_ff, hold98_in;
   logic [LEVEL_W-1:0]    new_hold;
   logic [LEVEL_W-1:0]    meter_val;
   logic [apm_pkg::SQRT_IN_W-1:0]  radicand;
   logic [apm_pkg::SQRT_OUT_W-1:0] root;
   logic                  sqrt_busy;

   // Result register.
   logic [LEVEL_W-1:0] peak_out_ff, peak_out_in;
   logic [LEVEL_W-1:0] meter_out_ff, meter_out_in;
   logic [LEVEL_W-1:0] hold_out_ff, hold_out_in;

   apm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.tick_prep),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .root     (root)
   );

   always_comb begin
      fmt_in    = fmt_ff;
      stereo_in = stereo_ff;
      speed_in  = speed_ff;
      if (csr_we) begin
         if (csr_index == apm_pkg::CSR_SAMPLE_FORMAT) begin
            fmt_in = apm_pkg::sample_format_type'(csr_wdata);
         end
         if (csr_index == apm_pkg::CSR_STEREO) begin
            stereo_in = csr_wdata[0];
         end
         if (csr_index == apm_pkg::CSR_RESPONSE_SPEED) begin
            speed_in = csr_wdata;
         end
      end
   end

   always_comb begin
      info_in[0] = info_ff[0];
      info_in[1] = info_ff[1];
      if (cmd.latch_frame) begin
         info_in[0] = decode(req_left_sample, fmt_ff);
         info_in[1] = stereo_ff ? decode(req_right_sample, fmt_ff) : '0;
      end
      for (int i = 0; i < 2; i++) begin
         prod_in[i] = cmd.frame_mul ?
                      {{(PROD_W - SAMPLE_W){1'b0}}, info_ff[i].mant} * FS_PROD : prod_ff[i];
         lvl[i]     = clip(prod_ff[i], info_ff[i].shamt, info_ff[i].full);
      end
      merged = peak_ff;
      if (lvl[0] > merged) begin
         merged = lvl[0];
      end
      if (lvl[1] > merged) begin
         merged = lvl[1];
      end
   end

   always_comb begin
      unique case (speed_ff)
         apm_pkg::SPEED_FAST: keep_k = K_FAST;
         apm_pkg::SPEED_SLOW: keep_k = K_SLOW;
         default:             keep_k = K_NORMAL;
      endcase
      decay_prod = DPROD_W'(peak_ff) * DPROD_W'(keep_k);
      hold_prod  = DPROD_W'(hold_ff) * DPROD_W'(K_HOLD);
      meter_prod = MPROD_W'(peak_ff) * MPROD_W'(apm_pkg::METER_MUL);
      radicand   = apm_pkg::SQRT_IN_W'(meter_prod >> apm_pkg::METER_SHIFT);
      decay_in   = cmd.tick_prep ? decay_prod[DECAY_S +: LEVEL_W] : decay_ff;
      hold98_in  = cmd.tick_prep ? hold_prod[DECAY_S +: LEVEL_W] : hold98_ff;
      new_hold   = (peak_ff > hold_ff) ? peak_ff : hold98_ff;
      meter_val  = (root > apm_pkg::SQRT_OUT_W'(apm_pkg::FULL_SCALE)) ?
                   FS_LEVEL : root[LEVEL_W-1:0];
   end

   always_comb begin
      peak_in      = peak_ff;
      hold_in      = hold_ff;
      peak_out_in  = peak_out_ff;
      meter_out_in = meter_out_ff;
      hold_out_in  = hold_out_ff;
      if (cmd.frame_merge) begin
         peak_in = merged;
      end
      if (cmd.clear_hold) begin
         hold_in = '0;
      end
      if (cmd.tick_commit) begin
         peak_in      = decay_ff;
         hold_in      = new_hold;
         peak_out_in  = peak_ff;
         meter_out_in = meter_val;
         hold_out_in  = new_hold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= apm_pkg::FMT_INT16;
         stereo_ff <= 1'b1;
         speed_ff  <= apm_pkg::SPEED_NORMAL;
         peak_ff   <= '0;
         hold_ff   <= '0;
      end else begin
         fmt_ff    <= fmt_in;
         stereo_ff <= stereo_in;
         speed_ff  <= speed_in;
         peak_ff   <= peak_in;
         hold_ff   <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      info_ff[0]   <= info_in[0];
      info_ff[1]   <= info_in[1];
      prod_ff[0]   <= prod_in[0];
      prod_ff[1]   <= prod_in[1];
      decay_ff     <= decay_in;
      hold98_ff    <= hold98_in;
      peak_out_ff  <= peak_out_in;
      meter_out_ff <= meter_out_in;
      hold_out_ff  <= hold_out_in;
   end

   assign status.sqrt_busy = sqrt_busy;
   assign rsp_peak_level   = peak_out_ff;
   assign rsp_meter_level  = meter_out_ff;
   assign rsp_hold_level   = hold_out_ff;

endmodule

[src/apm_ctrl.sv]
// Controller of the audio peak meter: request decode, sequencing and result valid.
// Depends on apm_pkg for the state, command and status types.
module apm_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [apm_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic                              req_silent,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  apm_pkg::status_type               status,
   output apm_pkg::cmd_type                  cmd
);

   apm_pkg::state_type   state_ff, state_in;
   apm_pkg::req_code_type req_code;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign req_code = apm_pkg::req_code_type'(req_type);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apm_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_code)
                  apm_pkg::REQ_FRAME: begin
                     if (!req_silent) begin
                        state_in = apm_pkg::ST_FRAME_MUL;
                     end
                  end
                  apm_pkg::REQ_TICK: state_in = apm_pkg::ST_TICK_PREP;
                  default:           state_in = apm_pkg::ST_IDLE;
               endcase
            end
         end
         apm_pkg::ST_FRAME_MUL:   state_in = apm_pkg::ST_FRAME_MERGE;
         apm_pkg::ST_FRAME_MERGE: state_in = apm_pkg::ST_IDLE;
         apm_pkg::ST_TICK_PREP:   state_in = apm_pkg::ST_TICK_SQRT;
         apm_pkg::ST_TICK_SQRT: begin
            if (!status.sqrt_busy) begin
               state_in = apm_pkg::ST_TICK_OUT;
            end
         end
         apm_pkg::ST_TICK_OUT: begin
            if (out_free) begin
               state_in = apm_pkg::ST_IDLE;
            end
         end
         default: state_in = apm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         apm_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.latch_frame = req_valid && (req_code == apm_pkg::REQ_FRAME) && !req_silent;
            cmd.clear_hold  = req_valid && (req_code == apm_pkg::REQ_CLEAR);
         end
         apm_pkg::ST_FRAME_MUL:   cmd.frame_mul   = 1'b1;
         apm_pkg::ST_FRAME_MERGE: cmd.frame_merge = 1'b1;
         apm_pkg::ST_TICK_PREP:   cmd.tick_prep   = 1'b1;
         apm_pkg::ST_TICK_OUT:    cmd.tick_commit = out_free;
         default:                 cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.tick_commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[tb/testbench.sv]
// Self-checking testbench for audio_peak_meter_with_hold: directed table, then random phases.
// Depends on apm_pkg (request, register, format and speed codes) and the block's RTL only.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned LEVEL_W    = apm_pkg::LEVEL_W;
   localparam int unsigned FULL_SCALE = apm_pkg::FULL_SCALE;

   // Codes that the package leaves unnamed but that the block must still handle.
   localparam logic [1:0] REQ_RESERVED = 2'd3;   // request code three, dropped by the block
   localparam logic [1:0] SPEED_SPARE  = 2'd3;   // response code three, behaves as normal

   // Decay and scaling constants of the meter.
   localparam int unsigned KEEP_FAST   = 70;
   localparam int unsigned KEEP_NORMAL = 88;
   localparam int unsigned KEEP_SLOW   = 95;
   localparam int unsigned HOLD_KEEP   = 98;
   // 1.15 squared, in units of 1/10000, so the bar level is isqrt(1000 * peak * 13225) / 100.
   localparam longint unsigned BAR_GAIN_SQ = 13225;

   localparam int unsigned RESET_CYCLES = 9;
   localparam int unsigned MAX_GAP      = 17;
   // Covers a tick that keeps the block busy, with margin.
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned LONG_STALL    = 400;
   localparam int unsigned PHASES        = 12;
   localparam int unsigned PHASE_ITEMS   = 140;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [LEVEL_W-1:0] peak;
      logic [LEVEL_W-1:0] meter;
      logic [LEVEL_W-1:0] hold;
   } meter_reading_type;

   typedef enum logic { ROW_REQUEST, ROW_SETTINGS } row_kind_type;

   // One line of the directed script: either a request transaction or a full register set.
   typedef struct packed {
      row_kind_type        kind;
      logic [1:0]          code;
      logic [31:0]         left;
      logic [31:0]         right;
      logic                silent;
      logic                pinned;
      meter_reading_type   reading;
      logic [1:0]          fmt;
      logic [1:0]          stereo;
      logic [1:0]          speed;
   } script_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [apm_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [apm_pkg::SAMPLE_W-1:0]    req_left_sample;
   logic [apm_pkg::SAMPLE_W-1:0]    req_right_sample;
   logic                            req_silent;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [LEVEL_W-1:0]              rsp_peak_level;
   logic [LEVEL_W-1:0]              rsp_meter_level;
   logic [LEVEL_W-1:0]              rsp_hold_level;
   logic                            csr_we;
   logic [apm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [apm_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // A directed row may carry a hand-typed reading; it travels alongside the payload.
   logic                   pinned_valid;
   meter_reading_type      pinned_reading;

   // Readings that accepted ticks still owe, oldest first.
   meter_reading_type      readings_due[$];
   int unsigned            mismatch_count;

   // Knobs shared between the sender, the receiver and the phase control.
   bit                     send_idle;
   bit                     recv_idle;
   bit                     long_stall_req;
   logic [1:0]             drive_fmt;

   audio_peak_meter_with_hold uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_silent       (req_silent),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_meter_level  (rsp_meter_level),
      .rsp_hold_level   (rsp_hold_level),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is bounded no matter what the block does. The slowest correct run is
   // well under a million nanoseconds, so this leaves several times that.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------------------
   // Level prediction. All arithmetic is exact integer work at 64 bits.
   // ------------------------------------------------------------------------------------

   function automatic logic [LEVEL_W-1:0] clip_level(logic [63:0] v);
      return (v > FULL_SCALE) ? LEVEL_W'(FULL_SCALE) : v[LEVEL_W-1:0];
   endfunction

   // Two's complement word of the given width: the magnitude is scaled so that the most
   // negative code lands exactly on full scale, and the result is truncated.
   function automatic logic [LEVEL_W-1:0] level_of_int(logic [31:0] word, int unsigned bits);
      logic [31:0] mask;
      logic [31:0] v;
      logic [31:0] sign;
      logic [63:0] mag;
      mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
      v    = word & mask;
      sign = 32'd1 << (bits - 1);
      if ((v & sign) != 0)
         mag = {32'd0, (~v + 32'd1) & mask};
      else
         mag = {32'd0, v};
      return clip_level((mag * FULL_SCALE) >> (bits - 1));
   endfunction

   // IEEE single: |x| * full scale, floored, worked out from the mantissa and exponent so
   // that subnormals come out right. NaN reads as silence, infinity as full scale.
   function automatic logic [LEVEL_W-1:0] level_of_float(logic [31:0] word);
      logic [63:0] m;
      int unsigned ex;
      int unsigned sh;
      m  = {41'd0, word[22:0]};
      ex = {24'd0, word[30:23]};
      if (ex == 255)
         return (m != 0) ? LEVEL_W'(0) : LEVEL_W'(FULL_SCALE);
      if (ex == 0)
         ex = 1;
      else
         m = m | 64'h80_0000;
      if (ex >= 150)
         return (m != 0) ? LEVEL_W'(FULL_SCALE) : LEVEL_W'(0);
      sh = 150 - ex;
      if (sh >= 64)
         return LEVEL_W'(0);
      return clip_level((m * FULL_SCALE) >> sh);
   endfunction

   function automatic logic [LEVEL_W-1:0] level_of_word(logic [31:0] word, logic [1:0] fmt);
      case (fmt)
         apm_pkg::FMT_INT16: return level_of_int(word, 16);
         apm_pkg::FMT_INT24: return level_of_int(word, 24);
         apm_pkg::FMT_INT32: return level_of_int(word, 32);
         default:            return level_of_float(word);
      endcase
   endfunction

   // floor(1.15 * sqrt(1000 * peak)), kept at least 1 for a nonzero peak and capped.
   function automatic logic [LEVEL_W-1:0] bar_of_peak(logic [LEVEL_W-1:0] peak);
      logic [63:0] x;
      logic [63:0] root;
      logic [63:0] trial;
      if (peak == 0)
         return LEVEL_W'(0);
      x    = {54'd0, peak};
      x    = x * FULL_SCALE * BAR_GAIN_SQ;
      root = 64'd0;
      for (int i = 20; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x)
            root = trial;
      end
      root = root / 100;
      if (root < 1)
         root = 64'd1;
      return clip_level(root);
   endfunction

   task automatic note_failure(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------------------
   // Scoreboard. Everything is sampled on the rising edge; the inputs were set up at the
   // falling edge before, and the block's registered outputs still hold their pre-edge
   // values here. Responses are checked before the request of the same edge is absorbed,
   // since a tick accepted now cannot have its reading on the output yet.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      logic [1:0]         shadow_format;
      logic               shadow_stereo;
      logic [1:0]         shadow_speed;
      logic [LEVEL_W-1:0] running_level;
      logic [LEVEL_W-1:0] held_level;
      logic [LEVEL_W-1:0] chan;
      int unsigned        keep;
      meter_reading_type  got;
      meter_reading_type  want;
      meter_reading_type  fresh;

      if (reset) begin
         shadow_format = apm_pkg::FMT_INT16;
         shadow_stereo = 1'b1;
         shadow_speed  = apm_pkg::SPEED_NORMAL;
         running_level = '0;
         held_level    = '0;
         readings_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               apm_pkg::CSR_SAMPLE_FORMAT:  shadow_format = csr_wdata;
               apm_pkg::CSR_STEREO:         shadow_stereo = csr_wdata[0];
               apm_pkg::CSR_RESPONSE_SPEED: shadow_speed  = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            got.peak  = rsp_peak_level;
            got.meter = rsp_meter_level;
            got.hold  = rsp_hold_level;
            if (readings_due.size() == 0) begin
               note_failure($sformatf("response with no tick pending: peak %0d meter %0d hold %0d",
                                      got.peak, got.meter, got.hold));
            end else begin
               want = readings_due.pop_front();
               if (got.peak !== want.peak)
                  note_failure($sformatf("peak_level expected %0d, got %0d", want.peak, got.peak));
               if (got.meter !== want.meter)
                  note_failure($sformatf("meter_level expected %0d, got %0d",
                                         want.meter, got.meter));
               if (got.hold !== want.hold)
                  note_failure($sformatf("hold_level expected %0d, got %0d", want.hold, got.hold));
            end
         end

         if (req_valid && req_ready) begin
            case (req_type)
               apm_pkg::REQ_FRAME: begin
                  if (!req_silent) begin
                     chan = level_of_word(req_left_sample, shadow_format);
                     if (chan > running_level)
                        running_level = chan;
                     if (shadow_stereo) begin
                        chan = level_of_word(req_right_sample, shadow_format);
                        if (chan > running_level)
                           running_level = chan;
                     end
                  end
               end
               apm_pkg::REQ_TICK: begin
                  // Report the peak as it stands, update the hold, then let the peak fall.
                  fresh.peak  = running_level;
                  fresh.meter = bar_of_peak(running_level);
                  if (running_level > held_level)
                     held_level = running_level;
                  else
                     held_level = LEVEL_W'((held_level * HOLD_KEEP) / 100);
                  fresh.hold = held_level;
                  keep = (shadow_speed == apm_pkg::SPEED_FAST) ? KEEP_FAST :
                         (shadow_speed == apm_pkg::SPEED_SLOW) ? KEEP_SLOW : KEEP_NORMAL;
                  running_level = LEVEL_W'((running_level * keep) / 100);
                  readings_due.push_back(pinned_valid ? pinned_reading : fresh);
               end
               apm_pkg::REQ_CLEAR: held_level = '0;
               default: ;   // reserved code: taken and dropped
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Response side. Before each response transaction the receiver may hold ready low for a
   // random number of cycles. When asked, it instead holds off for a long stretch so the
   // output register fills and the block has to stall its request side.
   // ------------------------------------------------------------------------------------
   initial begin : receiver
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            gap = LONG_STALL;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------------------
   // Request side helpers. Every task starts and ends at a falling edge, and no task
   // touches req_valid twice in one time step.
   // ------------------------------------------------------------------------------------
   task automatic send_request(logic [1:0] code, logic [31:0] left, logic [31:0] right,
                               logic silent, logic pin, meter_reading_type pin_reading);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= code;
      req_left_sample  <= left;
      req_right_sample <= right;
      req_silent       <= silent;
      pinned_valid     <= pin;
      pinned_reading   <= pin_reading;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops offering requests until every owed reading has been taken, then lets the
   // block finish any frame or tick still in flight.
   task automatic wait_for_readings();
      req_valid <= 1'b0;
      @(negedge clock);
      while (readings_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all three registers, one per cycle, with the block idle.
   task automatic apply_settings(logic [1:0] fmt, logic [1:0] stereo, logic [1:0] speed);
      wait_for_readings();
      csr_we    <= 1'b1;
      csr_index <= apm_pkg::CSR_SAMPLE_FORMAT;
      csr_wdata <= fmt;
      @(negedge clock);
      csr_index <= apm_pkg::CSR_STEREO;
      csr_wdata <= stereo;
      @(negedge clock);
      csr_index <= apm_pkg::CSR_RESPONSE_SPEED;
      csr_wdata <= speed;
      @(negedge clock);
      csr_we    <= 1'b0;
      drive_fmt = fmt;
   endtask

   // A sample word with a good chance of landing somewhere meaningful for the format in
   // use: in-range integers of every size, boundary codes, floats around unity, and noise.
   function automatic logic [31:0] pick_sample(logic [1:0] fmt);
      logic [31:0] w;
      logic [31:0] mant;
      logic [7:0]  expo;
      int unsigned bits;
      bits = (fmt == apm_pkg::FMT_INT16) ? 16 : (fmt == apm_pkg::FMT_INT24) ? 24 : 32;
      case ($urandom_range(0, 4))
         0: begin
            w = $urandom >> (32 - bits + $urandom_range(0, bits - 1));
            if ($urandom_range(0, 1))
               w = ~w + 32'd1;
         end
         1: begin
            case ($urandom_range(0, 11))
               0:  w = 32'h0000_8000;
               1:  w = 32'h0000_7FFF;
               2:  w = 32'h0080_0000;
               3:  w = 32'h007F_FFFF;
               4:  w = 32'h8000_0000;
               5:  w = 32'h7FFF_FFFF;
               6:  w = 32'hFFFF_FFFF;
               7:  w = 32'h0000_0000;
               8:  w = 32'h7F80_0000;
               9:  w = 32'hFF80_0000;
               10: w = 32'h7FC0_0000 | $urandom_range(0, 32'h3F_FFFF);
               default: w = $urandom_range(0, 32'h7F_FFFF);
            endcase
         end
         2: begin
            expo = 8'($urandom_range(100, 160));
            mant = $urandom;
            w    = {($urandom_range(0, 1) == 1), expo, mant[22:0]};
         end
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // Mostly frames with a steady share of ticks, plus clears, silent frames and the
   // reserved code for noise.
   task automatic send_random_request();
      int unsigned       roll;
      logic [1:0]        code;
      logic              silent;
      meter_reading_type none;
      none   = '0;
      roll   = $urandom_range(0, 99);
      silent = ($urandom_range(0, 9) == 0);
      if (roll < 62)
         code = apm_pkg::REQ_FRAME;
      else if (roll < 88)
         code = apm_pkg::REQ_TICK;
      else if (roll < 94)
         code = apm_pkg::REQ_CLEAR;
      else
         code = REQ_RESERVED;
      if (code != apm_pkg::REQ_FRAME)
         silent = 1'($urandom_range(0, 1));
      send_request(code, pick_sample(drive_fmt), pick_sample(drive_fmt), silent, 1'b0, none);
   endtask

   function automatic script_row_type req_row(logic [1:0] code, logic [31:0] left,
                                              logic [31:0] right, logic silent);
      script_row_type r;
      r        = '0;
      r.kind   = ROW_REQUEST;
      r.code   = code;
      r.left   = left;
      r.right  = right;
      r.silent = silent;
      return r;
   endfunction

   function automatic script_row_type pinned_tick(int unsigned peak, int unsigned meter,
                                                  int unsigned hold);
      script_row_type r;
      r               = req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0);
      r.pinned        = 1'b1;
      r.reading.peak  = LEVEL_W'(peak);
      r.reading.meter = LEVEL_W'(meter);
      r.reading.hold  = LEVEL_W'(hold);
      return r;
   endfunction

   function automatic script_row_type settings_row(logic [1:0] fmt, logic [1:0] stereo,
                                                   logic [1:0] speed);
      script_row_type r;
      r        = '0;
      r.kind   = ROW_SETTINGS;
      r.fmt    = fmt;
      r.stereo = stereo;
      r.speed  = speed;
      return r;
   endfunction

   // ------------------------------------------------------------------------------------
   // Stimulus: reset, the directed script, then random phases under varying settings.
   // ------------------------------------------------------------------------------------
   initial begin : stimulus
      script_row_type script[$];
      logic [1:0]     fmt;
      logic [1:0]     stereo;
      logic [1:0]     speed;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = apm_pkg::REQ_FRAME;
      req_left_sample  = '0;
      req_right_sample = '0;
      req_silent       = 1'b0;
      csr_we           = 1'b0;
      csr_index        = apm_pkg::CSR_SAMPLE_FORMAT;
      csr_wdata        = '0;
      pinned_valid     = 1'b0;
      pinned_reading   = '0;
      mismatch_count   = 0;
      send_idle        = 1'b1;
      recv_idle        = 1'b1;
      long_stall_req   = 1'b0;
      drive_fmt        = apm_pkg::FMT_INT16;

      // Reset settings: 16-bit, stereo, normal decay.
      // A tick straight after reset sees nothing at all.
      script.push_back(pinned_tick(0, 0, 0));
      // Most negative 16-bit code on the left reads exactly full scale; the largest
      // positive code on the right falls just short.
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'h0000_8000, 32'h0000_7FFF, 1'b0));
      // Full-scale peak: the bar saturates and the hold jumps to the peak.
      script.push_back(pinned_tick(1000, 1000, 1000));
      // Peak has decayed below the hold, so the hold decays too.
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      // A silent frame and the reserved code must both leave the peak alone.
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'hFFFF_8000, 32'hFFFF_8000, 1'b1));
      script.push_back(req_row(REQ_RESERVED, 32'hFFFF_8000, 32'h8000_8000, 1'b0));
      // Only the low 16 bits count: these are tiny samples with junk above.
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'hFFFF_0001, 32'hABCD_0000, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));

      // 24-bit mono, fast decay: the loud right channel must be ignored.
      script.push_back(settings_row(apm_pkg::FMT_INT24, 2'd0, apm_pkg::SPEED_FAST));
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'h0000_0100, 32'h0080_0000, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'hFF80_0000, 32'h0000_0000, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));

      // 32-bit stereo, slow decay, both integer extremes.
      script.push_back(settings_row(apm_pkg::FMT_INT32, 2'd1, apm_pkg::SPEED_SLOW));
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));

      // Float with the spare response code. NaN counts as zero, infinity as full scale,
      // huge exponents clip, subnormals vanish.
      script.push_back(settings_row(apm_pkg::FMT_FLOAT, 2'd1, SPEED_SPARE));
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'h7FC0_0000, 32'hFF80_0000, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'h3F80_0000, 32'h0000_0001, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'hBF00_0000, 32'h4F00_0000, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_FRAME, 32'h3A83_126F, 32'h7F80_0000, 1'b0));
      script.push_back(req_row(apm_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_SETTINGS)
            apply_settings(script[i].fmt, script[i].stereo, script[i].speed);
         else
            send_request(script[i].code, script[i].left, script[i].right, script[i].silent,
                         script[i].pinned, script[i].reading);
      end

      // Random phases. The first four pin down the register extremes; the rest draw
      // every register freely, including values with spare upper bits.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               fmt = apm_pkg::FMT_INT16; stereo = 2'd1; speed = apm_pkg::SPEED_FAST;
            end
            1: begin
               fmt = apm_pkg::FMT_FLOAT; stereo = 2'd0; speed = apm_pkg::SPEED_SLOW;
            end
            2: begin
               fmt = apm_pkg::FMT_INT32; stereo = 2'd1; speed = SPEED_SPARE;
            end
            3: begin
               fmt = apm_pkg::FMT_INT24; stereo = 2'd1; speed = apm_pkg::SPEED_NORMAL;
            end
            default: begin
               fmt    = 2'($urandom_range(0, 3));
               stereo = 2'($urandom_range(0, 3));
               speed  = 2'($urandom_range(0, 3));
            end
         endcase
         apply_settings(fmt, stereo, speed);

         // Some phases run with no gaps at all on one side or both.
         send_idle = (p % 3 != 2);
         recv_idle = (p % 4 != 3);
         if (p == 5) begin
            // Back-pressure: the receiver holds off for a long stretch while the sender
            // keeps offering back to back, so ticks pile up and the request side stalls.
            send_idle      = 1'b0;
            long_stall_req = 1'b1;
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Midway through one phase the sender pauses until all readings are in.
            if (p == 8 && n == PHASE_ITEMS / 2)
               wait_for_readings();
            send_random_request();
         end
      end

      wait_for_readings();
      mismatch_count += readings_due.size();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
